// ===== hdl/md5_pkg.sv =====
package md5_pkg;

    localparam int WORD_W    = 32;
    localparam int IDX_W     = 4;
    localparam int ADDR_W    = IDX_W + 1;
    localparam int BUF_DEPTH = 1 << ADDR_W;
    localparam int ROUNDS    = 64;
    localparam int RND_W     = 6;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [RND_W-1:0]  rnd_t;

    // Status of the block queue as seen by the compression engine.
    typedef struct packed {
        logic avail;   // at least one complete block waits in the buffer
        logic last;    // the waiting block closes a message
        logic bank;    // buffer half that holds it
    } md5_blk_t;

    localparam word_t INIT_A = 32'h67452301;
    localparam word_t INIT_B = 32'hefcdab89;
    localparam word_t INIT_C = 32'h98badcfe;
    localparam word_t INIT_D = 32'h10325476;

    localparam word_t SINE_K [ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Left-rotate amounts, indexed by {round group, round mod 4}.
    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message word used by a round.
    function automatic logic [IDX_W-1:0] msg_idx(input rnd_t r);
        logic [IDX_W-1:0] lo;
        lo = r[IDX_W-1:0];
        case (r[RND_W-1:IDX_W])
            2'd0:    msg_idx = lo;
            2'd1:    msg_idx = IDX_W'(lo * 4'd5 + 4'd1);
            2'd2:    msg_idx = IDX_W'(lo * 4'd3 + 4'd5);
            default: msg_idx = IDX_W'(lo * 4'd7);
        endcase
    endfunction

    function automatic logic [4:0] rot_of(input rnd_t r);
        rot_of = ROT_AMT[{r[5:4], r[1:0]}];
    endfunction

    // Round function F, G, H or I depending on the group of sixteen rounds.
    function automatic word_t round_fn(input rnd_t r, input word_t b, input word_t c,
                                       input word_t d);
        case (r[RND_W-1:IDX_W])
            2'd0:    round_fn = (b & c) | (~b & d);
            2'd1:    round_fn = (d & b) | (~d & c);
            2'd2:    round_fn = b ^ c ^ d;
            default: round_fn = c ^ (b | ~d);
        endcase
    endfunction

    function automatic word_t rotl(input word_t x, input logic [4:0] s);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} << s;
        rotl = dbl[2*WORD_W-1:WORD_W];
    endfunction

endpackage

// ===== hdl/md5_ram.sv =====
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/md5_front.sv =====
module md5_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  md5_pkg::word_t             s_word,
    input  logic                       s_tlast,
    output logic                       wr_en,
    output logic [md5_pkg::ADDR_W-1:0] wr_addr,
    output md5_pkg::word_t             wr_data,
    input  logic                       blk_release,
    output md5_pkg::md5_blk_t          blk
);
    import md5_pkg::*;

    logic [IDX_W-1:0] word_cnt_reg;
    logic             wr_bank_reg;
    logic             rd_bank_reg;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;
    logic [1:0]       last_reg;
    logic             accept;
    logic             block_done;

    // Two buffer halves: one fills while the engine works on the other.
    assign s_tready   = (fill_reg != 2'd2);
    assign accept     = s_tvalid && s_tready;
    assign block_done = accept && (word_cnt_reg == IDX_W'(15));

    assign wr_en   = accept;
    assign wr_addr = {wr_bank_reg, word_cnt_reg};
    assign wr_data = s_word;

    always_comb begin
        fill_next = fill_reg;
        if (block_done && !blk_release) begin
            fill_next = fill_reg + 2'd1;
        end else if (!block_done && blk_release) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_cnt_reg <= '0;
            wr_bank_reg  <= 1'b0;
            rd_bank_reg  <= 1'b0;
            fill_reg     <= 2'd0;
            last_reg     <= 2'b00;
        end else begin
            if (accept) begin
                word_cnt_reg <= word_cnt_reg + IDX_W'(1);
            end
            if (block_done) begin
                // Only the end flag on the closing word of a block counts.
                last_reg[wr_bank_reg] <= s_tlast;
                wr_bank_reg           <= ~wr_bank_reg;
            end
            if (blk_release) begin
                rd_bank_reg <= ~rd_bank_reg;
            end
            fill_reg <= fill_next;
        end
    end

    assign blk.avail = (fill_reg != 2'd0);
    assign blk.last  = last_reg[rd_bank_reg];
    assign blk.bank  = rd_bank_reg;

endmodule

// ===== hdl/md5_back.sv =====
module md5_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  md5_pkg::md5_blk_t          blk,
    output logic                       blk_release,
    output logic [md5_pkg::ADDR_W-1:0] rd_addr,
    input  md5_pkg::word_t             rd_data,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [4*md5_pkg::WORD_W-1:0] m_tdata
);
    import md5_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH
    } state_t;

    state_t state_reg;
    rnd_t   round_reg;
    rnd_t   round_next;
    word_t  a_reg, b_reg, c_reg, d_reg;
    word_t  b_next;
    word_t  pre_reg;
    word_t  pre_next;
    word_t  cv_a_reg, cv_b_reg, cv_c_reg, cv_d_reg;
    word_t  sum_a, sum_b, sum_c, sum_d;
    word_t  t_sum;
    logic [4*WORD_W-1:0] out_data_reg;
    logic   out_valid_reg;
    logic   out_free;
    logic   digest_load;

    assign round_next = round_reg + RND_W'(1);

    // Next round's word is addressed ahead of the registered read.
    always_comb begin
        case (state_reg)
            ST_ROUND: rd_addr = {blk.bank, msg_idx(round_next)};
            default:  rd_addr = {blk.bank, IDX_W'(0)};
        endcase
    end

    // pre_reg already holds A + K for this round.
    assign t_sum    = round_fn(round_reg, b_reg, c_reg, d_reg) + pre_reg + rd_data;
    assign b_next   = b_reg + rotl(t_sum, rot_of(round_reg));
    assign pre_next = d_reg + SINE_K[round_next];

    assign sum_a = cv_a_reg + a_reg;
    assign sum_b = cv_b_reg + b_reg;
    assign sum_c = cv_c_reg + c_reg;
    assign sum_d = cv_d_reg + d_reg;

    assign out_free    = !out_valid_reg || m_tready;
    assign blk_release = (state_reg == ST_FINISH) && (!blk.last || out_free);
    assign digest_load = blk_release && blk.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
            cv_a_reg      <= INIT_A;
            cv_b_reg      <= INIT_B;
            cv_c_reg      <= INIT_C;
            cv_d_reg      <= INIT_D;
        end else begin
            if (out_valid_reg && m_tready && !digest_load) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (blk.avail) begin
                        a_reg     <= cv_a_reg;
                        b_reg     <= cv_b_reg;
                        c_reg     <= cv_c_reg;
                        d_reg     <= cv_d_reg;
                        pre_reg   <= cv_a_reg + SINE_K[0];
                        round_reg <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    a_reg     <= d_reg;
                    b_reg     <= b_next;
                    c_reg     <= b_reg;
                    d_reg     <= c_reg;
                    pre_reg   <= pre_next;
                    round_reg <= round_next;
                    if (round_reg == RND_W'(ROUNDS - 1)) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (blk_release) begin
                        if (blk.last) begin
                            out_data_reg  <= {sum_d, sum_c, sum_b, sum_a};
                            out_valid_reg <= 1'b1;
                            cv_a_reg      <= INIT_A;
                            cv_b_reg      <= INIT_B;
                            cv_c_reg      <= INIT_C;
                            cv_d_reg      <= INIT_D;
                        end else begin
                            cv_a_reg <= sum_a;
                            cv_b_reg <= sum_b;
                            cv_c_reg <= sum_c;
                            cv_d_reg <= sum_d;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hdl/md5_block_hash.sv =====
// MD5 compression engine for already padded messages.
// Input requests carry one 32-bit little-endian message word in s_tdata; s_tlast
// marks words of the final block of a message, and only its value on the sixteenth
// word of a block is used. Sixteen words make one 512-bit block.
// The front end writes words into one half of a two-block buffer at one word per
// cycle while the compression engine works on the other half, so up to two full
// blocks may wait before s_tready falls.
// Each block takes a start step, 64 rounds on a single round unit (one round per
// cycle) and a finish step that adds into the chaining value. The sustained rate
// is therefore set by that round unit; the engine takes the next block only after
// the finish step of the current one. After the closing block of a message the
// digest is loaded into the output register when the finish step releases the
// block, and m_tvalid is driven from that register. Non-final blocks give no
// result request.
// When the receiver stalls, the digest is held in the output register; the engine
// waits at the end of the next closing block until that register is free, and
// input requests keep flowing until both buffer halves are full.
// Reset clears the word count, the buffer occupancy and the output valid, and sets
// the chaining value to the MD5 initial values; buffer contents are left as they are.
module md5_block_hash (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] message_word
    input  logic         s_tlast,   // message_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [31:0] digest_a, [63:32] digest_b,
                                    // [95:64] digest_c, [127:96] digest_d
);
    import md5_pkg::*;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    word_t             wr_data;
    logic [ADDR_W-1:0] rd_addr;
    word_t             rd_data;
    logic              blk_release;
    md5_blk_t          blk;

    md5_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_word      (s_tdata),
        .s_tlast     (s_tlast),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .blk_release (blk_release),
        .blk         (blk)
    );

    // Two 16-word halves of the message buffer.
    md5_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    md5_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .blk         (blk),
        .blk_release (blk_release),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // The engine only hands back a buffer half that holds a complete block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        blk_release |-> blk.avail)
        else $error("buffer half released while none was full");

    // Input back-pressure only arises when a full block is waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> blk.avail)
        else $error("input stalled with no block waiting");

    // A new digest is only presented when the engine retires a closing block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(blk_release && blk.last))
        else $error("digest presented without a finished closing block");

endmodule
